@@ rtl/snt_pkg.sv @@
// Shared types and constants of the strip noise tracker.
// Holds fixed-point widths, opcode and register codes, and the control
// structs between the sequencer and the iterative divide/root unit.
package snt_pkg;

  localparam int unsigned STRIPS_DEF = 4096;
  localparam int unsigned FRAC_BITS  = 8;

  localparam int unsigned VW  = 29;  // internal signed value width
  localparam int unsigned PW  = 48;  // product and numerator width
  localparam int unsigned RW  = 20;  // square root result width
  localparam int unsigned DIV_STEPS  = 30;
  localparam int unsigned SQRT_STEPS = 20;
  localparam int unsigned DEN_SHIFT  = DIV_STEPS - 1;
  localparam int unsigned ROOT_TOP   = 2 * (SQRT_STEPS - 1);

  localparam logic [16:0] NOISE_MAX = 17'h1FFFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic [7:0] REG_FOLLOW  = 8'd0;
  localparam logic [7:0] REG_OUTLIER = 8'd1;

  typedef enum logic {
    IT_DIV  = 1'b0,
    IT_SQRT = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic              start;
    iter_mode_t        mode;
    logic signed [PW-1:0] num;
    logic [16:0]       den;
  } iter_req_t;

  typedef struct packed {
    logic              done;
    logic signed [PW-1:0] quot;
    logic [RW-1:0]     root;
  } iter_rsp_t;

endpackage

@@ rtl/snt_iter.sv @@
// Shared iterative unit: signed floor division one quotient bit per cycle,
// or integer square root one result bit per cycle.
// Depends on snt_pkg.
module snt_iter
  import snt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  iter_req_t req,
  output iter_rsp_t rsp
);

  logic [PW-1:0] rem;
  logic [PW-1:0] acc;
  logic [PW-1:0] dsh;
  logic [4:0]    cnt;
  logic          busy;
  logic          neg;
  logic          done;
  iter_mode_t    mode;
  logic [PW-1:0] trial;
  logic [PW-1:0] mag;

  assign trial = (mode == IT_SQRT) ? acc + dsh : dsh;
  assign mag   = req.num[PW-1] ? PW'(-req.num) : PW'(req.num);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.mode;
        acc  <= '0;
        if (req.mode == IT_SQRT) begin
          rem <= req.num[PW-1] ? '0 : PW'(req.num);
          neg <= 1'b0;
          dsh <= PW'(1) << ROOT_TOP;
          cnt <= 5'(SQRT_STEPS - 1);
        end else begin
          rem <= mag;
          neg <= req.num[PW-1];
          dsh <= PW'({req.den, {DEN_SHIFT{1'b0}}});
          cnt <= 5'(DIV_STEPS - 1);
        end
      end else if (busy) begin
        if (mode == IT_SQRT) begin
          if (rem >= trial) begin
            rem <= rem - trial;
            acc <= (acc >> 1) + dsh;
          end else begin
            acc <= acc >> 1;
          end
          dsh <= dsh >> 2;
        end else begin
          if (rem >= trial) begin
            rem <= rem - trial;
            acc <= {acc[PW-2:0], 1'b1};
          end else begin
            acc <= {acc[PW-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.root = acc[RW-1:0];
    if (neg) begin
      rsp.quot = -$signed(acc) - $signed(PW'(rem != '0));
    end else begin
      rsp.quot = $signed(acc);
    end
  end

endmodule

@@ rtl/strip_noise_tracker_top.sv @@
// Strip noise tracker: per-strip running mean and RMS noise of three ADC values.
// Holds the statistics and settings memories and the sequencer around snt_iter.
// Depends on snt_pkg and snt_iter.
//
// Input beats on s_axis carry a load (tuser = 1) or a sample (tuser = 0).
// A load writes a strip's threshold and enable and gives no result.
// A sample reads the strip, updates count, means and mean-squares when the strip
// passes the enable and outlier test, then answers with one m_axis beat holding
// the means and the noise; tuser on m_axis is the updated flag.
// An updating sample runs six divisions and then three square roots, and a skipped
// sample in range runs only the three square roots, all on the single shared
// divide/root unit that works one bit a cycle.
// s_axis_tready is high only while the sequencer is idle.
// After reset the block clears both memories, one strip a cycle, before it
// takes input; configuration writes are taken at any time.
// Registers reset to following_period = 0 and remove_outliers = 1.
// A stalled m_axis holds the result; the next item may be taken meanwhile but
// its result waits until the held beat leaves.
module strip_noise_tracker_top
  import snt_pkg::*;
#(
  parameter int unsigned STRIPS = STRIPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // strip_index[11:0], raw_adc[21:12], pedsub_adc[31:22], cms_adc[41:32],
  // threshold_value[56:42], strip_enable[57], zero[63:58]
  input  logic [63:0]  s_axis_tdata,
  // opcode[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_strip[11:0], raw_mean[29:12], raw_noise[46:30], pedsub_mean[64:47],
  // pedsub_noise[81:65], cms_mean[99:82], cms_noise[116:100], zero[119:117]
  output logic [119:0] m_axis_tdata,
  // was_updated[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  localparam int unsigned AW = $clog2(STRIPS);
  localparam int unsigned SW = 152;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_SETUP = 11'b000_0000_0100,
    S_MUL   = 11'b000_0000_1000,
    S_ADD   = 11'b000_0001_0000,
    S_DIV   = 11'b000_0010_0000,
    S_SQM   = 11'b000_0100_0000,
    S_SQV   = 11'b000_1000_0000,
    S_SQRT  = 11'b001_0000_0000,
    S_DONE  = 11'b010_0000_0000
  } state_t;

  state_t state;

  logic [SW-1:0] stat_mem [STRIPS];
  logic [15:0]   set_mem  [STRIPS];
  logic [SW-1:0] stat_rd;
  logic [15:0]   set_rd;

  logic [15:0] follow_period;
  logic        remove_outliers;

  logic [AW-1:0] clr_cnt;
  logic [AW-1:0] in_idx;
  logic [AW-1:0] idx;
  logic [11:0]   strip;
  logic          in_range;
  logic          s_accept;
  logic          in_ok;

  logic [9:0] raw_adc, raw_r;
  logic signed [9:0] ped_adc, cms_adc, ped_r, cms_r;

  logic signed [VW-1:0] val [6];
  logic signed [VW-1:0] xs  [6];
  logic [16:0] nz [3];
  logic [2:0]  cnt;
  logic [15:0] n_reg;
  logic        upd;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] mul_p;
  logic signed [VW-1:0] mul_a;
  logic signed [18:0]   mul_b;
  logic signed [PW-1:0] num;
  logic signed [PW-1:0] var_w;

  logic        pass;
  logic [9:0]  acms;
  logic [16:0] n_inc;
  logic [15:0] n_new;
  logic [19:0] raw_sq;
  logic signed [19:0] ped_sq, cms_sq;

  logic          stat_we;
  logic [AW-1:0] stat_wa;
  logic [SW-1:0] stat_wd;

  iter_req_t req;
  iter_rsp_t rsp;

  snt_iter u_iter (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_idx        = AW'(s_axis_tdata[11:0]);
  assign in_ok         = (32'(s_axis_tdata[11:0]) < STRIPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_period   <= '0;
      remove_outliers <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FOLLOW:  follow_period   <= cfg_data;
        REG_OUTLIER: remove_outliers <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memories
  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      set_mem[clr_cnt] <= '0;
    end else if (s_accept && s_axis_tuser == OP_LOAD && in_ok) begin
      set_mem[in_idx] <= {s_axis_tdata[57], s_axis_tdata[56:42]};
    end
    if (s_accept) begin
      set_rd <= set_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    if (s_accept) begin
      stat_rd <= stat_mem[in_idx];
    end
  end

  assign stat_we = (state == S_CLEAR) ||
                   (state == S_DONE && upd && (!m_axis_tvalid || m_axis_tready));
  assign stat_wa = (state == S_CLEAR) ? clr_cnt : idx;
  assign stat_wd = (state == S_CLEAR) ? '0 :
                   {val[5][26:0], val[4][17:0], val[3][26:0], val[2][17:0],
                    val[1][27:0], val[0][17:0], n_reg};

  // Setup arithmetic
  assign raw_adc = raw_r;
  assign ped_adc = ped_r;
  assign cms_adc = cms_r;
  assign acms    = cms_adc[9] ? 10'(-cms_adc) : 10'(cms_adc);
  assign pass    = set_rd[15] &&
                   (!remove_outliers || ({1'b0, acms, 4'b0} <= set_rd[14:0]));
  assign n_inc   = {1'b0, stat_rd[15:0]} + 17'd1;
  always_comb begin
    if (follow_period != '0 && n_inc > {1'b0, follow_period}) begin
      n_new = follow_period;
    end else if (n_inc[16]) begin
      n_new = 16'hFFFF;
    end else begin
      n_new = n_inc[15:0];
    end
  end
  assign raw_sq = raw_adc * raw_adc;
  assign ped_sq = ped_adc * ped_adc;
  assign cms_sq = cms_adc * cms_adc;

  // Shared multiplier
  assign mul_a = val[0];
  assign mul_b = (state == S_MUL) ? $signed({3'b000, n_reg - 16'd1}) : val[0][18:0];
  assign mul_p = mul_a * mul_b;
  assign num   = prod + PW'(xs[0]);
  assign var_w = ($signed(PW'(val[1])) <<< FRAC_BITS) - prod;

  always_comb begin
    req.start = 1'b0;
    req.mode  = IT_DIV;
    req.num   = (num <<< 1) + $signed(PW'(n_reg));
    req.den   = {n_reg, 1'b0};
    if (state == S_ADD) begin
      req.start = 1'b1;
    end else if (state == S_SQV) begin
      req.start = 1'b1;
      req.mode  = IT_SQRT;
      req.num   = var_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      upd           <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(STRIPS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_accept && s_axis_tuser == OP_SAMPLE) begin
            strip    <= s_axis_tdata[11:0];
            idx      <= in_idx;
            in_range <= in_ok;
            raw_r    <= s_axis_tdata[21:12];
            ped_r    <= s_axis_tdata[31:22];
            cms_r    <= s_axis_tdata[41:32];
            state    <= S_SETUP;
          end
        end
        S_SETUP: begin
          val[0] <= VW'(stat_rd[33:16]);
          val[1] <= VW'(stat_rd[61:34]);
          val[2] <= VW'($signed(stat_rd[79:62]));
          val[3] <= VW'(stat_rd[106:80]);
          val[4] <= VW'($signed(stat_rd[124:107]));
          val[5] <= VW'(stat_rd[151:125]);
          xs[0]  <= VW'($signed({1'b0, raw_adc})) <<< FRAC_BITS;
          xs[1]  <= VW'(raw_sq) <<< FRAC_BITS;
          xs[2]  <= VW'(ped_adc) <<< FRAC_BITS;
          xs[3]  <= VW'(ped_sq) <<< FRAC_BITS;
          xs[4]  <= VW'(cms_adc) <<< FRAC_BITS;
          xs[5]  <= VW'(cms_sq) <<< FRAC_BITS;
          n_reg  <= n_new;
          upd    <= in_range && pass;
          cnt    <= '0;
          if (!in_range) begin
            state <= S_DONE;
          end else if (pass) begin
            state <= S_MUL;
          end else begin
            state <= S_SQM;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_ADD;
        end
        S_ADD: state <= S_DIV;
        S_DIV: begin
          if (rsp.done) begin
            for (int i = 0; i < 5; i++) begin
              val[i] <= val[i+1];
              xs[i]  <= xs[i+1];
            end
            val[5] <= VW'(rsp.quot);
            xs[5]  <= xs[0];
            if (cnt == 3'd5) begin
              cnt   <= '0;
              state <= S_SQM;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= S_MUL;
            end
          end
        end
        S_SQM: begin
          prod  <= mul_p;
          state <= S_SQV;
        end
        S_SQV: state <= S_SQRT;
        S_SQRT: begin
          if (rsp.done) begin
            nz[2] <= (rsp.root > RW'(NOISE_MAX)) ? NOISE_MAX : rsp.root[16:0];
            nz[1] <= nz[2];
            nz[0] <= nz[1];
            for (int i = 0; i < 6; i++) begin
              val[i] <= val[(i + 2) % 6];
            end
            if (cnt == 3'd2) begin
              state <= S_DONE;
            end else begin
              cnt   <= cnt + 3'd1;
              state <= S_SQM;
            end
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= upd;
            if (in_range) begin
              m_axis_tdata <= {3'b0, nz[2], val[4][17:0], nz[1], val[2][17:0],
                               nz[0], val[0][17:0], strip};
            end else begin
              m_axis_tdata <= {108'b0, strip};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_stat_write_src: assert property (@(posedge clk) disable iff (rst)
    stat_we |-> (state == S_DONE || state == S_CLEAR))
    else $error("statistics written outside clear or done");

  a_iter_done_state: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == S_DIV || state == S_SQRT))
    else $error("unit finished while sequencer not waiting");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (n_reg != '0))
    else $error("average step with zero count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == S_DONE))
    else $error("result raised outside done");

endmodule

@@ verif/strip_noise_tracker_checker.sv @@
// Checker for the strip noise tracker: watches input, config and result beats,
// predicts each result from its own copy of the strip statistics and compares.
// Depends on snt_pkg.
`timescale 1ns / 1ps
module strip_noise_tracker_checker
  import snt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [119:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic               updated;
    logic [119:0]       data;
  } strip_result_t;

  localparam int NSTRIP = 4096;

  logic [15:0] cnt_mem [NSTRIP];
  longint      mean_mem [NSTRIP][3];
  longint      msq_mem  [NSTRIP][3];
  logic [14:0] thr_mem  [NSTRIP];
  logic        en_mem   [NSTRIP];
  logic [15:0] follow_period;
  logic        drop_outliers;
  strip_result_t result_q[$];

  assign pending = result_q.size();

  function automatic longint run_avg(longint old, longint x, longint n);
    longint num, a, d, q;
    num = old * (n - 1) + x;
    a = 2 * num + n;
    d = 2 * n;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [16:0] rms_of(longint m, longint sq);
    longint v, r;
    v = sq * 256 - m * m;
    if (v <= 0) return 17'd0;
    r = longint'($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return (r > 131071) ? 17'h1FFFF : r[16:0];
  endfunction

  function automatic strip_result_t predict_sample(logic [63:0] d);
    strip_result_t res;
    logic [11:0] s;
    longint x[3];
    longint acms, n;
    s = d[11:0];
    x[0] = d[21:12];
    x[1] = longint'(signed'(d[31:22]));
    x[2] = longint'(signed'(d[41:32]));
    acms = x[2] < 0 ? -x[2] : x[2];
    res = '0;
    res.data[11:0] = s;
    if (en_mem[s] && (!drop_outliers || acms * 16 <= longint'(thr_mem[s]))) begin
      n = cnt_mem[s] + 1;
      if (follow_period != 0 && n > follow_period) n = follow_period;
      if (n > 65535) n = 65535;
      cnt_mem[s] = n[15:0];
      for (int k = 0; k < 3; k++) begin
        mean_mem[s][k] = run_avg(mean_mem[s][k], x[k] * 256, n);
        msq_mem[s][k] = run_avg(msq_mem[s][k], x[k] * x[k] * 256, n);
      end
      res.updated = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      res.data[12 + 35*k +: 18] = mean_mem[s][k][17:0];
      res.data[30 + 35*k +: 17] = rms_of(mean_mem[s][k], msq_mem[s][k]);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    strip_result_t e;
    if (rst) begin
      for (int i = 0; i < NSTRIP; i++) begin
        cnt_mem[i] = '0;
        thr_mem[i] = '0;
        en_mem[i] = 1'b0;
        for (int k = 0; k < 3; k++) begin
          mean_mem[i][k] = 0;
          msq_mem[i][k] = 0;
        end
      end
      follow_period = '0;
      drop_outliers = 1'b1;
      fail_count = 0;
      result_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_FOLLOW) follow_period = cfg_data;
        else if (cfg_index == REG_OUTLIER) drop_outliers = cfg_data[0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OP_LOAD) begin
          thr_mem[s_axis_tdata[11:0]] = s_axis_tdata[56:42];
          en_mem[s_axis_tdata[11:0]] = s_axis_tdata[57];
        end else begin
          result_q.insert(result_q.size(), predict_sample(s_axis_tdata));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", m_axis_tdata);
        end else begin
          e = result_q.pop_front();
          if (e.data !== m_axis_tdata || e.updated !== m_axis_tuser) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch strip %0d: exp upd=%b data=%h, got upd=%b data=%h",
                       e.data[11:0], e.updated, e.data, m_axis_tuser, m_axis_tdata);
          end
        end
      end
    end
  end

endmodule

@@ verif/strip_noise_tracker_top_tb.sv @@
// Testbench top for the strip noise tracker: drives loads, samples and register
// writes under varied idling, and reports the checker's verdict.
// Depends on snt_pkg, strip_noise_tracker_top and strip_noise_tracker_checker.
`timescale 1ns / 1ps
module strip_noise_tracker_top_tb;
  import snt_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [119:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  int           fail_count;
  int           pending;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           quiet_cycles = 0;
  logic [11:0]  hot_strips[8];

  always #5 clk = ~clk;

  strip_noise_tracker_top dut (.*);

  strip_noise_tracker_checker chk (.*);

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles > 20000) begin
      $display("** strip_noise_tracker_top: FAILED **");
      $finish;
    end
  end

  task automatic send_beat(logic op, logic [11:0] s, logic [9:0] raw, logic [9:0] ped,
                           logic [9:0] cms, logic [14:0] thr, logic en);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, en, thr, cms, ped, raw, s};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_beat;
    logic [11:0] s;
    int r;
    r = $urandom_range(99);
    s = (r < 75) ? hot_strips[$urandom_range(7)] : 12'($urandom);
    if ($urandom_range(99) < 12)
      send_beat(OP_LOAD, s, 10'($urandom), 10'($urandom), 10'($urandom),
                15'($urandom), ($urandom_range(9) != 0));
    else if ($urandom_range(3) == 0)
      send_beat(OP_SAMPLE, s, 10'($urandom), 10'($urandom), 10'($urandom), '0, 0);
    else
      send_beat(OP_SAMPLE, s, 10'(400 + $urandom_range(60)), 10'($urandom_range(40) - 20),
                10'($urandom_range(16) - 8), 15'($urandom), 0);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) hot_strips[i] = 12'($urandom);
    hot_strips[0] = 12'd0;
    hot_strips[1] = 12'hFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (!s_axis_tready) @(posedge clk);

    // directed: disabled strip, loads, extremes, outlier edge
    send_beat(OP_SAMPLE, 12'd0, 10'h3FF, 10'h200, 10'h1FF, '0, 0);
    send_beat(OP_LOAD, 12'd0, '0, '0, '0, 15'h7FFF, 1);
    send_beat(OP_LOAD, 12'hFFF, '0, '0, '0, 15'd80, 1);
    send_beat(OP_LOAD, 12'd5, '0, '0, '0, 15'd0, 1);
    send_beat(OP_SAMPLE, 12'd0, 10'h3FF, 10'h200, 10'h200, '0, 0);
    send_beat(OP_SAMPLE, 12'd0, 10'h000, 10'h1FF, 10'h1FF, '0, 0);
    send_beat(OP_SAMPLE, 12'd0, 10'h3FF, 10'h200, 10'h200, '0, 0);
    send_beat(OP_SAMPLE, 12'hFFF, 10'd100, 10'd5, 10'd5, '0, 0);
    send_beat(OP_SAMPLE, 12'hFFF, 10'd100, 10'd5, 10'd6, '0, 0);
    send_beat(OP_SAMPLE, 12'hFFF, 10'd120, 10'h3FB, 10'h3FB, '0, 0);
    send_beat(OP_SAMPLE, 12'd5, 10'd7, 10'd0, 10'd0, '0, 0);
    send_beat(OP_SAMPLE, 12'd5, 10'd7, 10'd1, 10'd1, '0, 0);
    send_beat(OP_LOAD, 12'd5, '0, '0, '0, 15'd0, 0);
    send_beat(OP_SAMPLE, 12'd5, 10'd9, 10'd0, 10'd0, '0, 0);
    drain();
    write_reg(REG_OUTLIER, 16'd0);
    write_reg(REG_FOLLOW, 16'd1);
    send_beat(OP_SAMPLE, 12'hFFF, 10'h3FF, 10'h200, 10'h200, '0, 0);
    send_beat(OP_SAMPLE, 12'hFFF, 10'd0, 10'h1FF, 10'h1FF, '0, 0);
    drain();
    write_reg(REG_FOLLOW, 16'hFFFF);
    write_reg(8'd7, 16'h1234);

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 64 : (ph == 4 ? 9 : 0);
      recv_stall_pct = (ph == 2 || ph == 3) ? 64 : (ph == 4 ? 9 : 0);
      for (int i = 0; i < 240; i++) random_beat();
      drain();
      case (ph)
        0: begin write_reg(REG_FOLLOW, 16'd4); write_reg(REG_OUTLIER, 16'd1); end
        1: write_reg(REG_FOLLOW, 16'd0);
        2: begin write_reg(REG_FOLLOW, 16'd16); write_reg(REG_OUTLIER, 16'd0); end
        3: write_reg(REG_OUTLIER, 16'd1);
        default: ;
      endcase
    end
    drain();
    if (fail_count == 0)
      $display("** strip_noise_tracker_top: PASSED **");
    else
      $display("** strip_noise_tracker_top: FAILED **");
    $finish;
  end

endmodule
